>>> sv/vpa_pkg.sv
// Package for the variable partition allocator: sizes, codes, beat structs.
// No dependencies; used by every module of the block.
package vpa_pkg;

  localparam int TableEntries = 32;
  localparam int MemoryUnits  = 1024;
  localparam int IdxW   = $clog2(TableEntries);
  localparam int CntW   = $clog2(TableEntries + 1);
  localparam int StartW = $clog2(MemoryUnits);
  localparam int SizeW  = $clog2(MemoryUnits + 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_SPARE = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_NO_FIT     = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_FREED      = 3'd3,
    ST_CLEARED    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_COMMIT,
    S_FREE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  owner_id;
    logic [10:0] request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_index;
    logic [9:0]  entry_start;
    logic [5:0]  freed_count;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, reset cursor
    logic clear;     // restore one whole-memory partition
    logic scan;      // examine entry at cursor
    logic shift;     // move one entry up, cursor walks down
    logic commit;    // write chosen entry and split remainder
    logic free_step; // release entry at cursor if owned
    logic set_rsp;   // latch response
    status_e status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;   // cursor at last live entry
    logic found;       // a candidate has been chosen
    logic stop_first;  // first-fit hit, scan may end
    logic need_split;
    logic full;
    logic shift_done;
  } sts_t;

endpackage

>>> sv/variable_partition_allocator_top.sv
// Top level of the variable partition allocator: controller plus datapath.
// Depends on vpa_pkg, vpa_ctrl and vpa_datapath.
//
// An item is taken when start_i is high and busy_o low; its single result is
// on rsp_o when done_o is high for exactly one cycle, and the receiver cannot
// stall it. An unused op code is dropped without a result. Clear goes to the
// done state at once; free walks every live entry, then ends in the done
// state; allocate scans entries (first fit stops at the hit), decides, on a
// split moves the entries above the chosen one up one by one, then commits
// and ends in the done state. A refused allocation skips the shift and commit
// states. The worst case is a split of entry 0 in a 31-entry table. All of it
// is stepped by the single table cursor. The policy register is written
// through cfg_valid_i/cfg_ready_o.
module variable_partition_allocator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vpa_pkg::req_t  req_i,
  output logic           busy_o,
  output logic           done_o,
  output vpa_pkg::rsp_t  rsp_o,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_data_i,
  output logic           cfg_ready_o
);
  import vpa_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] fit_policy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q <= POL_FIRST;
    end else if (cfg_valid_i) begin
      fit_policy_q <= cfg_data_i;
    end
  end

  vpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i && !busy_o),
    .op_i   (req_i.op),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  vpa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .fit_policy_i(fit_policy_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

>>> sv/vpa_ctrl.sv
// Sequencer for the allocator: scan, shift, commit and free passes.
// Depends on vpa_pkg.
module vpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [1:0]     op_i,
  input  vpa_pkg::sts_t  sts_i,
  output vpa_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);
  import vpa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op_e'(op_i))
            OP_ALLOC: state_d = S_SCAN;
            OP_FREE:  state_d = S_FREE;
            OP_CLEAR: state_d = S_DONE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN:   if (sts_i.scan_last || sts_i.stop_first) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!sts_i.found) state_d = S_DONE;
        else if (sts_i.need_split && sts_i.full) state_d = S_DONE;
        else if (sts_i.need_split) state_d = S_SHIFT;
        else state_d = S_COMMIT;
      end
      S_SHIFT:  if (sts_i.shift_done) state_d = S_COMMIT;
      S_COMMIT: state_d = S_DONE;
      S_FREE:   if (sts_i.scan_last) state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.status = ST_NO_FIT;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        cmd_o.clear = start_i && (op_e'(op_i) == OP_CLEAR);
        if (op_e'(op_i) == OP_CLEAR) begin
          cmd_o.set_rsp = start_i;
          cmd_o.status = ST_CLEARED;
        end
      end
      S_SCAN: cmd_o.scan = 1'b1;
      S_DECIDE: begin
        if (!sts_i.found) begin
          cmd_o.set_rsp = 1'b1;
          cmd_o.status = ST_NO_FIT;
        end else if (sts_i.need_split && sts_i.full) begin
          cmd_o.set_rsp = 1'b1;
          cmd_o.status = ST_TABLE_FULL;
        end
      end
      S_SHIFT: cmd_o.shift = !sts_i.shift_done;
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        cmd_o.set_rsp = 1'b1;
        cmd_o.status = ST_ALLOCATED;
      end
      S_FREE: begin
        cmd_o.free_step = 1'b1;
        cmd_o.set_rsp = sts_i.scan_last;
        cmd_o.status = ST_FREED;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> sv/vpa_datapath.sv
// Partition table, cursor, candidate tracking and response register.
// Depends on vpa_pkg.
module vpa_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  vpa_pkg::req_t  req_i,
  input  logic [1:0]     fit_policy_i,
  input  vpa_pkg::cmd_t  cmd_i,
  output vpa_pkg::sts_t  sts_o,
  output vpa_pkg::rsp_t  rsp_o
);
  import vpa_pkg::*;

  // Table entries live in flip-flops: a shift touches two entries per cycle.
  logic [StartW-1:0] start_q [TableEntries];
  logic [SizeW-1:0]  size_q  [TableEntries];
  logic [7:0]        owner_q [TableEntries];
  logic [TableEntries-1:0] free_q;
  logic [CntW-1:0]   count_q;

  req_t            req_q;
  logic [IdxW-1:0] cur_q;
  logic [IdxW-1:0] best_q;
  logic            found_q;
  logic [CntW-1:0] freed_q;
  rsp_t            rsp_q;
  rsp_t            rsp_d;

  logic [SizeW-1:0] best_size;
  logic             fits, better, owned;
  logic [IdxW-1:0]  next_idx;
  logic [StartW-1:0] rem_start;

  assign best_size = size_q[best_q];
  assign fits  = free_q[cur_q] && (size_q[cur_q] >= req_q.request_size)
                 && (req_q.request_size != '0);
  always_comb begin
    case (policy_e'(fit_policy_i))
      POL_BEST:  better = size_q[cur_q] < best_size;
      POL_WORST: better = size_q[cur_q] > best_size;
      default:   better = 1'b0;
    endcase
  end
  assign owned = !free_q[cur_q] && (owner_q[cur_q] == req_q.owner_id);
  assign next_idx = best_q + 1'b1;
  assign rem_start = start_q[best_q] + StartW'(req_q.request_size);

  assign sts_o.scan_last  = ({1'b0, cur_q} == count_q - 1'b1);
  assign sts_o.found      = found_q;
  assign sts_o.stop_first = fits && !(policy_e'(fit_policy_i) == POL_BEST
                                     || policy_e'(fit_policy_i) == POL_WORST);
  assign sts_o.need_split = best_size > req_q.request_size;
  assign sts_o.full       = (count_q == CntW'(TableEntries));
  assign sts_o.shift_done = (cur_q == next_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= TableEntries'(1);
      count_q <= CntW'(1);
      found_q <= 1'b0;
      cur_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        cur_q   <= '0;
        found_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        free_q  <= TableEntries'(1);
        count_q <= CntW'(1);
      end
      if (cmd_i.scan) begin
        if (fits && (!found_q || better)) found_q <= 1'b1;
        if (!sts_o.scan_last && !sts_o.stop_first) cur_q <= cur_q + 1'b1;
        else cur_q <= count_q[IdxW-1:0];
      end
      if (cmd_i.shift) begin
        free_q[cur_q] <= free_q[cur_q - 1'b1];
        cur_q <= cur_q - 1'b1;
      end
      if (cmd_i.commit) begin
        free_q[best_q] <= 1'b0;
        if (sts_o.need_split) begin
          free_q[next_idx] <= 1'b1;
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.free_step) begin
        if (owned) free_q[cur_q] <= 1'b1;
        if (!sts_o.scan_last) cur_q <= cur_q + 1'b1;
      end
    end
  end

  // Payload registers: no reset needed apart from entry 0 set by clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q[0] <= '0;
      size_q[0]  <= SizeW'(MemoryUnits);
    end else begin
      if (cmd_i.clear) begin
        start_q[0] <= '0;
        size_q[0]  <= SizeW'(MemoryUnits);
      end
      if (cmd_i.shift) begin
        start_q[cur_q] <= start_q[cur_q - 1'b1];
        size_q[cur_q]  <= size_q[cur_q - 1'b1];
        owner_q[cur_q] <= owner_q[cur_q - 1'b1];
      end
      if (cmd_i.commit) begin
        owner_q[best_q] <= req_q.owner_id;
        if (sts_o.need_split) begin
          size_q[best_q]    <= req_q.request_size;
          start_q[next_idx] <= rem_start;
          size_q[next_idx]  <= best_size - req_q.request_size;
          owner_q[next_idx] <= '0;
        end
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.status = cmd_i.status;
    if (cmd_i.status == ST_ALLOCATED) begin
      rsp_d.entry_index = 5'(best_q);
      rsp_d.entry_start = 10'(start_q[best_q]);
    end
    if (cmd_i.status == ST_FREED) begin
      rsp_d.freed_count = 6'(freed_q + CntW'(owned));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_i;
      freed_q <= '0;
    end
    if (cmd_i.scan && fits && (!found_q || better)) best_q <= cur_q;
    if (cmd_i.free_step && owned) freed_q <= freed_q + 1'b1;
    if (cmd_i.set_rsp) rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

>>> bench/variable_partition_allocator_top_tb.sv
// Self-checking bench for the variable partition allocator top level.
// Depends on vpa_pkg and variable_partition_allocator_top; keeps its own table model.
module variable_partition_allocator_top_tb;
  import vpa_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o, cfg_ready_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_data_i = '0;

  variable_partition_allocator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o),
    .cfg_valid_i(cfg_valid_i), .cfg_data_i(cfg_data_i), .cfg_ready_o(cfg_ready_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  localparam int WatchLimit = 20000;

  // Shadow copy of the partition table.
  logic [9:0]  tbl_start [TableEntries];
  logic [10:0] tbl_size  [TableEntries];
  logic        tbl_free  [TableEntries];
  logic [7:0]  tbl_owner [TableEntries];
  int          tbl_count;
  policy_e     policy;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   failures = 0;
  int   idle_cycles = 0;
  int   gap = 0;

  function automatic void clear_shadow();
    tbl_start[0] = '0;
    tbl_size[0]  = 11'(MemoryUnits);
    tbl_free[0]  = 1'b1;
    tbl_owner[0] = '0;
    tbl_count    = 1;
  endfunction

  function automatic int choose_part(int need);
    int pick;
    pick = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_size[i] >= need) begin
        if (pick < 0) begin
          pick = i;
          if (policy != POL_BEST && policy != POL_WORST) return pick;
        end else if (policy == POL_BEST && tbl_size[i] < tbl_size[pick]) begin
          pick = i;
        end else if (policy == POL_WORST && tbl_size[i] > tbl_size[pick]) begin
          pick = i;
        end
      end
    end
    return pick;
  endfunction

  // Applies one request to the shadow table and returns whether it answers.
  function automatic bit apply_request(req_t r, output rsp_t a);
    int k;
    int cnt;
    a = '0;
    case (op_e'(r.op))
      OP_ALLOC: begin
        k = (r.request_size == 0) ? -1 : choose_part(r.request_size);
        if (k < 0) begin
          a.status = ST_NO_FIT;
        end else if (tbl_size[k] > r.request_size && tbl_count >= TableEntries) begin
          a.status = ST_TABLE_FULL;
        end else begin
          if (tbl_size[k] > r.request_size) begin
            for (int j = tbl_count; j > k + 1; j--) begin
              tbl_start[j] = tbl_start[j-1];
              tbl_size[j]  = tbl_size[j-1];
              tbl_free[j]  = tbl_free[j-1];
              tbl_owner[j] = tbl_owner[j-1];
            end
            tbl_start[k+1] = tbl_start[k] + 10'(r.request_size);
            tbl_size[k+1]  = tbl_size[k] - r.request_size;
            tbl_free[k+1]  = 1'b1;
            tbl_owner[k+1] = '0;
            tbl_size[k]    = r.request_size;
            tbl_count++;
          end
          tbl_free[k]  = 1'b0;
          tbl_owner[k] = r.owner_id;
          a.status = ST_ALLOCATED;
          a.entry_index = 5'(k);
          a.entry_start = tbl_start[k];
        end
        return 1'b1;
      end
      OP_FREE: begin
        cnt = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_free[i] && tbl_owner[i] == r.owner_id) begin
            tbl_free[i] = 1'b1;
            tbl_owner[i] = '0;
            cnt++;
          end
        end
        a.status = ST_FREED;
        a.freed_count = 6'(cnt);
        return 1'b1;
      end
      OP_CLEAR: begin
        clear_shadow();
        a.status = ST_CLEARED;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  // Driver: one request beat per accepted start, then a random gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        void'(pending_reqs.pop_front());
        start_i <= 1'b0;
        gap <= pick_gap();
      end else if (start_i) begin
        // Keep the current beat on the port until it is taken.
      end else if (gap > 0) begin
        gap <= gap - 1;
      end else if (pending_reqs.size() != 0) begin
        start_i <= 1'b1;
        req_i <= pending_reqs[0];
      end
    end
  end

  // Predicts at acceptance, compares at the strobe.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    rsp_t got;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start_i && !busy_o) begin
        if (apply_request(req_i, exp_rsp)) expected_rsps.push_back(exp_rsp);
      end
      if (done_o) begin
        got = rsp_o;
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected: status %0d", got.status);
          failures++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (got.status != exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
            failures++;
          end
          if (got.entry_index != exp_rsp.entry_index) begin
            $error("entry_index: expected %0d, got %0d", exp_rsp.entry_index,
                   got.entry_index);
            failures++;
          end
          if (got.entry_start != exp_rsp.entry_start) begin
            $error("entry_start: expected %0d, got %0d", exp_rsp.entry_start,
                   got.entry_start);
            failures++;
          end
          if (got.freed_count != exp_rsp.freed_count) begin
            $error("freed_count: expected %0d, got %0d", exp_rsp.freed_count,
                   got.freed_count);
            failures++;
          end
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("[variable_partition_allocator_top] ERROR");
        $finish;
      end
    end
  end

  function automatic req_t make_req(op_e o, int pid, int sz);
    req_t r;
    r.op = o;
    r.owner_id = 8'(pid);
    r.request_size = 11'(sz);
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || start_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    // An ignored op may still be in flight.
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_policy(policy_e p);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= p;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    policy = p;
  endtask

  task automatic random_phase(int n);
    int live [$];
    int pid;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        pid = $urandom_range(0, 255);
        if ($urandom_range(0, 9) < 8) pid = $urandom_range(0, 7);
        case ($urandom_range(0, 9))
          0: pending_reqs.push_back(make_req(OP_ALLOC, pid, $urandom_range(0, 2047)));
          1: pending_reqs.push_back(make_req(OP_ALLOC, pid, $urandom_range(512, 1024)));
          default: pending_reqs.push_back(make_req(OP_ALLOC, pid, $urandom_range(1, 64)));
        endcase
      end else if (roll < 90) begin
        pid = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 255);
        pending_reqs.push_back(make_req(OP_FREE, pid, $urandom_range(0, 2047)));
      end else if (roll < 95) begin
        pending_reqs.push_back(make_req(OP_CLEAR, $urandom_range(0, 255),
                                        $urandom_range(0, 2047)));
      end else begin
        pending_reqs.push_back(make_req(OP_NONE, $urandom_range(0, 255),
                                        $urandom_range(0, 2047)));
        i--;
        if ($urandom_range(0, 1) == 0) i++;
      end
    end
  endtask

  initial begin
    clear_shadow();
    policy = POL_FIRST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, every op, full table, zero and oversized sizes.
    pending_reqs.push_back(make_req(OP_ALLOC, 255, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 0, 2047));
    pending_reqs.push_back(make_req(OP_ALLOC, 1, 1025));
    pending_reqs.push_back(make_req(OP_ALLOC, 1, 1024));
    pending_reqs.push_back(make_req(OP_ALLOC, 2, 1));
    pending_reqs.push_back(make_req(OP_FREE, 1, 0));
    pending_reqs.push_back(make_req(OP_FREE, 1, 0));
    pending_reqs.push_back(make_req(OP_NONE, 170, 1365));
    for (int i = 0; i < 31; i++) pending_reqs.push_back(make_req(OP_ALLOC, i, 1));
    pending_reqs.push_back(make_req(OP_ALLOC, 200, 5));
    pending_reqs.push_back(make_req(OP_ALLOC, 200, 993));
    pending_reqs.push_back(make_req(OP_FREE, 3, 0));
    pending_reqs.push_back(make_req(OP_ALLOC, 85, 1));
    pending_reqs.push_back(make_req(OP_CLEAR, 255, 2047));
    drain();

    write_policy(POL_BEST);
    random_phase(180);
    drain();
    write_policy(POL_WORST);
    random_phase(180);
    drain();
    write_policy(POL_SPARE);
    random_phase(150);
    drain();
    write_policy(POL_FIRST);
    random_phase(180);
    drain();

    if (failures == 0) begin
      $display("[variable_partition_allocator_top] OK");
    end else begin
      $display("[variable_partition_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
